FILE: hw/rtl/phm_pkg.sv
package phm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int TEMP_W   = 12;
	localparam int VOLT_W   = 16;
	localparam int PH_W     = 14;
	localparam int TK_W     = 13;
	localparam int IIR_W    = 20;

	// Bit-serial multiplier: A is the wide operand, B is consumed one bit per cycle
	localparam int MUL_AW = 24;
	localparam int MUL_BW = 18;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int MUL_CW = $clog2(MUL_BW);

	// Restoring divider: one quotient bit per cycle
	localparam int DIV_NW = 42;
	localparam int DIV_DW = 30;
	localparam int DIV_CW = $clog2(DIV_NW);

	localparam int CFG_IDX_W = 2;

	// Twice the 0.1 mV full scale, so the mean division can round half up
	localparam logic [MUL_AW-1:0] VOLT_SCALE_X2 = MUL_AW'(66000);
	// 518.0 * 298.0 scaled to thousandths of pH over 0.1 K
	localparam logic [MUL_AW-1:0] SLOPE_K       = MUL_AW'(15436400);
	localparam logic [TK_W-1:0]   KELVIN_DECI   = TK_W'(2730);
	localparam logic [DIV_DW-1:0] IIR_DIVISOR   = DIV_DW'(10);
	localparam logic [IIR_W-1:0]  IIR_ROUND     = IIR_W'(5);
	localparam logic [PH_W-1:0]   PH_MID        = PH_W'(6860);
	localparam logic [PH_W-1:0]   PH_MAX        = PH_W'(14000);
	localparam logic [PH_W-1:0]   PH_UP_SPAN    = PH_W'(7140);

	localparam logic [VOLT_W-1:0]   CAL_PH4_RST   = VOLT_W'(23600);
	localparam logic [VOLT_W-1:0]   CAL_PH686_RST = VOLT_W'(20000);
	localparam logic [VOLT_W-1:0]   CAL_PH918_RST = VOLT_W'(16700);
	localparam logic [SAMPLE_W-1:0] MIN_RST       = {SAMPLE_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_PH4   = 2'd0,
		REG_CAL_PH686 = 2'd1,
		REG_CAL_PH918 = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_MEAN_MUL,
		ST_MEAN_DIV,
		ST_IIR_DIV,
		ST_PH_MUL_NUM,
		ST_PH_MUL_DEN,
		ST_PH_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]      adc_sample;
		logic signed [TEMP_W-1:0] temp_deci_c;
	} sample_t;

	typedef struct packed {
		logic [PH_W-1:0]   ph_milli;
		logic [VOLT_W-1:0] filtered_voltage;
		logic              cal_error;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [MUL_PW-1:0] product;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

endpackage

FILE: hw/rtl/phm_accum.sv
module phm_accum import phm_pkg::*; #(
	parameter int SAMPLES_PER_RESULT = 8,
	localparam int CNT_W = $clog2(SAMPLES_PER_RESULT),
	localparam int SUM_W = SAMPLE_W + CNT_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                clear,
	input  logic [SAMPLE_W-1:0] adc,
	output logic                last,
	output logic [SUM_W-1:0]    trim
);

	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;

	assign last = (cnt_q == CNT_W'(SAMPLES_PER_RESULT - 1));
	// with two or more samples in the group, sum holds max and min, so this does not go negative
	assign trim = sum_q - SUM_W'(max_q) - SUM_W'(min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			max_q <= '0;
			min_q <= MIN_RST;
		end else if (clear) begin
			sum_q <= '0;
			max_q <= '0;
			min_q <= MIN_RST;
		end else if (take) begin
			cnt_q <= last ? '0 : cnt_q + 1'b1;
			sum_q <= sum_q + SUM_W'(adc);
			if (adc > max_q) max_q <= adc;
			if (adc < min_q) min_q <= adc;
		end
	end

endmodule

FILE: hw/rtl/phm_mul.sv
module phm_mul import phm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [MUL_AW-1:0] a_q;
	logic [MUL_PW-1:0] p_q;
	logic [MUL_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_AW:0]   sum;

	// Add A into the upper half when the current multiplier bit is set, then shift right
	assign sum = {1'b0, p_q[MUL_PW-1:MUL_BW]} + {1'b0, a_q & {MUL_AW{p_q[0]}}};

	assign rsp.done    = done_q;
	assign rsp.product = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CW'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			p_q <= {{MUL_AW{1'b0}}, req.b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MUL_BW-1:1]};
		end
	end

endmodule

FILE: hw/rtl/phm_div.sv
module phm_div import phm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW+1:0] diff;
	logic              fits;

	assign trial = {rem_q, n_q[DIV_NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = !diff[DIV_DW+1];

	assign rsp.done = done_q;
	assign rsp.quo  = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Numerator bits leave at the top as quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			n_q   <= {n_q[DIV_NW-2:0], fits};
		end
	end

endmodule

FILE: hw/rtl/ph_meter_trimmed_iir.sv
// Samples are taken one per cycle while a group gathers; its last sample closes the group.
// After the last sample of a group: mean multiply and divide, then IIR division (skipped on the first
// group, which loads the filter with the mean), then the pH multiplies and division (skipped on a
// calibration error). Samples are held off until the result enters the output register, so a stalled
// earlier result holds the block; all steps share the one bit-serial multiplier and divider.
// Reset (arst_n low) clears the group, unprimes the filter and restores the calibration defaults.
module ph_meter_trimmed_iir import phm_pkg::*; #(
	parameter int SAMPLES_PER_RESULT = 8,
	parameter int ADC_FULL_SCALE     = 4095
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_t              sample_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VOLT_W-1:0]    cfg_data
);

	localparam int    CNT_W        = $clog2(SAMPLES_PER_RESULT);
	localparam int    SUM_W        = SAMPLE_W + CNT_W;
	localparam longint MEAN_DEN    = longint'(ADC_FULL_SCALE) * longint'(SAMPLES_PER_RESULT - 2);
	localparam logic [DIV_NW-1:0] MEAN_BIAS    = DIV_NW'(MEAN_DEN);
	localparam logic [DIV_DW-1:0] MEAN_DIVISOR = DIV_DW'(2 * MEAN_DEN);

	seq_state_t state_q, state_d;
	logic       kick_q;

	logic [VOLT_W-1:0] v4_q, v686_q, v918_q;
	logic              primed_q;
	logic [VOLT_W-1:0] filter_q;
	logic [VOLT_W-1:0] mean_q;
	logic [MUL_PW-1:0] mn_q;
	logic              neg_q;
	logic [PH_W-1:0]   ph_q;
	logic [TEMP_W-1:0] temp_q;
	logic              result_valid_q;
	result_t           result_q;

	logic              take;
	logic              grp_last;
	logic              grp_clear;
	logic [SUM_W-1:0]  trim;
	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              cal_err;
	logic [VOLT_W:0]   dv;
	logic [VOLT_W:0]   dcal;
	logic [VOLT_W-1:0] dv_mag;
	logic [VOLT_W-1:0] dcal_mag;
	logic [TK_W-1:0]   tk;
	logic [IIR_W-1:0]  iir_num;
	logic [VOLT_W-1:0] mean_sat;
	logic [PH_W-1:0]   ph_n;

	assign sample_ready = (state_q == ST_ACC);
	assign take         = sample_valid && sample_ready;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	assign cal_err  = (v4_q == v918_q);
	assign dv       = {1'b0, filter_q} - {1'b0, v686_q};
	assign dcal     = {1'b0, v918_q} - {1'b0, v4_q};
	assign dv_mag   = dv[VOLT_W] ? VOLT_W'(-dv) : dv[VOLT_W-1:0];
	assign dcal_mag = dcal[VOLT_W] ? VOLT_W'(-dcal) : dcal[VOLT_W-1:0];
	// Absolute temperature in 0.1 K; positive for any 12-bit temperature
	assign tk       = KELVIN_DECI + TK_W'($signed(temp_q));
	assign iir_num  = IIR_W'({filter_q, 1'b0}) + IIR_W'(filter_q)
	                + IIR_W'({mean_q, 3'b000}) - IIR_W'(mean_q) + IIR_ROUND;
	assign mean_sat = (|div_rsp.quo[DIV_NW-1:VOLT_W]) ? {VOLT_W{1'b1}}
	                                                  : div_rsp.quo[VOLT_W-1:0];

	always_comb begin
		if (neg_q) begin
			ph_n = (div_rsp.quo > DIV_NW'(PH_MID)) ? '0
			     : PH_MID - PH_W'(div_rsp.quo[PH_W-2:0]);
		end else begin
			ph_n = (div_rsp.quo > DIV_NW'(PH_UP_SPAN)) ? PH_MAX
			     : PH_MID + PH_W'(div_rsp.quo[PH_W-2:0]);
		end
	end

	phm_accum #(
		.SAMPLES_PER_RESULT(SAMPLES_PER_RESULT)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.clear  (grp_clear),
		.adc    (sample_data.adc_sample),
		.last   (grp_last),
		.trim   (trim)
	);

	phm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	phm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			kick_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kick_q  <= (state_d != state_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		grp_clear = 1'b0;
		mul_req   = '0;
		div_req   = '0;
		case (state_q)
			ST_ACC: begin
				if (take && grp_last) state_d = ST_MEAN_MUL;
			end
			ST_MEAN_MUL: begin
				grp_clear     = kick_q;
				mul_req.start = kick_q;
				mul_req.a     = VOLT_SCALE_X2;
				mul_req.b     = MUL_BW'(trim);
				if (mul_rsp.done) state_d = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				div_req.start = kick_q;
				div_req.num   = DIV_NW'(mul_rsp.product) + MEAN_BIAS;
				div_req.den   = MEAN_DIVISOR;
				if (div_rsp.done) begin
					if (primed_q) state_d = ST_IIR_DIV;
					else if (cal_err) state_d = ST_DONE;
					else state_d = ST_PH_MUL_NUM;
				end
			end
			ST_IIR_DIV: begin
				div_req.start = kick_q;
				div_req.num   = DIV_NW'(iir_num);
				div_req.den   = IIR_DIVISOR;
				if (div_rsp.done) state_d = cal_err ? ST_DONE : ST_PH_MUL_NUM;
			end
			ST_PH_MUL_NUM: begin
				mul_req.start = kick_q;
				mul_req.a     = SLOPE_K;
				mul_req.b     = MUL_BW'(dv_mag);
				if (mul_rsp.done) state_d = ST_PH_MUL_DEN;
			end
			ST_PH_MUL_DEN: begin
				mul_req.start = kick_q;
				mul_req.a     = MUL_AW'(tk);
				mul_req.b     = MUL_BW'(dcal_mag);
				if (mul_rsp.done) state_d = ST_PH_DIV;
			end
			ST_PH_DIV: begin
				// Round half away from zero on magnitudes: (2n + d) / 2d
				div_req.start = kick_q;
				div_req.num   = {mn_q[DIV_NW-2:0], 1'b0} + DIV_NW'(mul_rsp.product);
				div_req.den   = {mul_rsp.product[DIV_DW-2:0], 1'b0};
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) state_d = ST_ACC;
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q           <= CAL_PH4_RST;
			v686_q         <= CAL_PH686_RST;
			v918_q         <= CAL_PH918_RST;
			primed_q       <= 1'b0;
			filter_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CAL_PH4:   v4_q   <= cfg_data;
					REG_CAL_PH686: v686_q <= cfg_data;
					REG_CAL_PH918: v918_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_MEAN_DIV && div_rsp.done && !primed_q) begin
				filter_q <= mean_sat;
				primed_q <= 1'b1;
			end
			if (state_q == ST_IIR_DIV && div_rsp.done) filter_q <= div_rsp.quo[VOLT_W-1:0];
			if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && grp_last) temp_q <= sample_data.temp_deci_c;
		if (state_q == ST_MEAN_DIV && div_rsp.done) mean_q <= mean_sat;
		if (state_q == ST_PH_MUL_NUM && mul_rsp.done) begin
			mn_q  <= mul_rsp.product;
			neg_q <= dv[VOLT_W] ^ dcal[VOLT_W];
		end
		if (state_q == ST_PH_DIV && div_rsp.done) ph_q <= ph_n;
		if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
			result_q.ph_milli         <= cal_err ? '0 : ph_q;
			result_q.filtered_voltage <= filter_q;
			result_q.cal_error        <= cal_err;
		end
	end

endmodule

FILE: hw/rtl/phm_checker.sv
module phm_checker import phm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_valid,
	input logic    sample_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result_data
);

	// Hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result transaction dropped or changed while stalled");

	a_err_zero_ph: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.cal_error |-> result_data.ph_milli == '0)
		else $error("calibration error with non-zero pH");

	a_ph_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.ph_milli <= PH_MAX)
		else $error("pH above full range");

	// A new result only comes out of the compute phase, when samples are held off
	a_result_from_compute: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!sample_ready))
		else $error("result appeared while gathering samples");

	// Leave the gathering phase only on an accepted sample transaction
	a_close_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) |-> $past(sample_valid))
		else $error("group closed without a sample");

endmodule

bind ph_meter_trimmed_iir phm_checker u_phm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);

FILE: tb/ph_meter_trimmed_iir_tb.sv
`timescale 1ns / 1ps

module ph_meter_trimmed_iir_tb import phm_pkg::*;;

	localparam int GROUP_LEN      = 8;
	localparam int ADC_FS         = 4095;
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int N_SETTINGS     = 12;
	localparam int GROUPS_PER_SET = 13;
	localparam int HOLD_PHASE     = 5;
	localparam int PAUSE_PHASE    = 9;
	localparam int LONG_HOLD      = 3000;
	localparam int SETTLE_CYCLES  = 250;
	localparam int DRAIN_CYCLES   = 400;
	localparam longint RUN_LIMIT_NS = 64'd10_000_000;

	localparam longint FULL_SCALE_X2 = 66000;
	localparam longint KELVIN_OFFSET = 2730;
	localparam longint NERNST_SLOPE  = 5180;
	localparam longint REF_KELVIN    = 2980;
	localparam longint PH_NEUTRAL    = 6860;
	localparam longint PH_CEIL       = 14000;
	localparam longint SWING_CAP     = 100000;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	// Three hand-picked groups: mixed extremes, full-scale, then all-zero
	localparam int DIR_ADC [3*GROUP_LEN] = '{
		0, 4095, 2048, 1, 4094, 1365, 2730, 4095,
		4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
		0, 0, 0, 0, 0, 0, 0, 0
	};
	localparam int DIR_TEMP [3*GROUP_LEN] = '{
		-400, 1250, -2048, 2047, 0, 1365, -1366, -2048,
		250, 250, 250, 250, 250, 250, 250, 2047,
		-400, 250, 250, 250, 250, 250, 250, 1250
	};

	class ph_scoreboard;
		logic [VOLT_W-1:0] cal_ph4;
		logic [VOLT_W-1:0] cal_ph686;
		logic [VOLT_W-1:0] cal_ph918;
		int unsigned       grp_count;
		int unsigned       grp_sum;
		int unsigned       grp_max;
		int unsigned       grp_min;
		int unsigned       iir_volt;
		bit                iir_loaded;
		result_t           pending_readings[$];
		int unsigned       errors;

		function new();
			cal_ph4    = 16'd23600;
			cal_ph686  = 16'd20000;
			cal_ph918  = 16'd16700;
			grp_count  = 0;
			grp_sum    = 0;
			grp_max    = 0;
			grp_min    = ADC_FS;
			iir_volt   = 0;
			iir_loaded = 1'b0;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VOLT_W-1:0] val);
			case (idx)
				REG_CAL_PH4:   cal_ph4   = val;
				REG_CAL_PH686: cal_ph686 = val;
				REG_CAL_PH918: cal_ph918 = val;
				default: ;
			endcase
		endfunction

		function int unsigned trimmed_mean_volt();
			longint trim;
			longint den;
			longint v;
			trim = longint'(grp_sum) - longint'(grp_max) - longint'(grp_min);
			den  = longint'(ADC_FS) * (GROUP_LEN - 2);
			v    = (trim * FULL_SCALE_X2 + den) / (2 * den);
			if (v > 65535)
				v = 65535;
			return int'(v);
		endfunction

		function logic [PH_W-1:0] compensated_ph(int unsigned v, int t);
			longint num;
			longint den;
			longint q;
			longint ph;
			bit     neg;
			num = (longint'(v) - longint'(cal_ph686)) * NERNST_SLOPE * REF_KELVIN;
			den = (longint'(cal_ph918) - longint'(cal_ph4)) * (KELVIN_OFFSET + t);
			neg = (num < 0) != (den < 0);
			if (num < 0)
				num = -num;
			if (den < 0)
				den = -den;
			// round half away from zero on magnitudes, then reapply the sign
			q = (2 * num + den) / (2 * den);
			if (q > SWING_CAP)
				q = SWING_CAP;
			ph = neg ? PH_NEUTRAL - q : PH_NEUTRAL + q;
			if (ph < 0)
				ph = 0;
			if (ph > PH_CEIL)
				ph = PH_CEIL;
			return PH_W'(ph);
		endfunction

		function void note_sample(sample_t s);
			int unsigned smp;
			int unsigned mean;
			result_t     r;
			smp = s.adc_sample;
			grp_sum += smp;
			if (smp > grp_max)
				grp_max = smp;
			if (smp < grp_min)
				grp_min = smp;
			grp_count++;
			if (grp_count < GROUP_LEN)
				return;
			mean      = trimmed_mean_volt();
			grp_count = 0;
			grp_sum   = 0;
			grp_max   = 0;
			grp_min   = ADC_FS;
			if (!iir_loaded) begin
				iir_volt   = mean;
				iir_loaded = 1'b1;
			end else begin
				iir_volt = (3 * iir_volt + 7 * mean + 5) / 10;
			end
			r.cal_error        = (cal_ph4 == cal_ph918);
			r.filtered_voltage = VOLT_W'(iir_volt);
			r.ph_milli         = r.cal_error ? '0
				: compensated_ph(iir_volt, int'($signed(s.temp_deci_c)));
			pending_readings.push_back(r);
		endfunction

		function void check_reading(result_t got);
			result_t want;
			if (pending_readings.size() == 0) begin
				$error("unexpected result: ph_milli %0d filtered_voltage %0d cal_error %0d",
					got.ph_milli, got.filtered_voltage, got.cal_error);
				errors++;
				return;
			end
			want = pending_readings.pop_front();
			if (got.ph_milli !== want.ph_milli) begin
				$error("ph_milli: expected %0d, actual %0d", want.ph_milli, got.ph_milli);
				errors++;
			end
			if (got.filtered_voltage !== want.filtered_voltage) begin
				$error("filtered_voltage: expected %0d, actual %0d",
					want.filtered_voltage, got.filtered_voltage);
				errors++;
			end
			if (got.cal_error !== want.cal_error) begin
				$error("cal_error: expected %0d, actual %0d", want.cal_error, got.cal_error);
				errors++;
			end
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 sample_valid  = 1'b0;
	logic                 sample_ready;
	sample_t              sample_data   = '0;
	logic                 result_valid;
	logic                 result_ready  = 1'b0;
	result_t              result_data;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [VOLT_W-1:0]    cfg_data      = '0;

	logic                 long_hold_req = 1'b0;
	int unsigned          src_idle_pct  = 30;
	int unsigned          sink_idle_pct = 65;

	logic [VOLT_W-1:0]    set_v4   [N_SETTINGS];
	logic [VOLT_W-1:0]    set_v686 [N_SETTINGS];
	logic [VOLT_W-1:0]    set_v918 [N_SETTINGS];

	ph_scoreboard sb;

	ph_meter_trimmed_iir #(
		.SAMPLES_PER_RESULT(GROUP_LEN),
		.ADC_FULL_SCALE    (ADC_FS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_data (sample_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data (result_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Observe every completed transaction at the edge that completes it
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				sb.note_sample(sample_data);
			if (result_valid && result_ready)
				sb.check_reading(result_data);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// Result sink: random back-pressure, or a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req <= 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	task automatic push_sample(input sample_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_data  <= s;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	task automatic send_group();
		int      style;
		int      base;
		int      spread;
		int      v;
		bit      wide_temp;
		sample_t s;
		style     = $urandom_range(99);
		base      = $urandom_range(4095);
		spread    = $urandom_range(64);
		wide_temp = ($urandom_range(99) < 15);
		for (int i = 0; i < GROUP_LEN; i++) begin
			if (style < 25) begin
				v = $urandom_range(4095);
			end else if (style < 40) begin
				case ($urandom_range(2))
					0: v = 0;
					1: v = 4095;
					default: v = base;
				endcase
			end else begin
				// settle around one level, with the odd spike for the trim to drop
				v = base + int'($urandom_range(2 * spread)) - spread;
				if ($urandom_range(99) < 15)
					v = $urandom_range(4095);
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end
			s.adc_sample = SAMPLE_W'(v);
			if (wide_temp)
				s.temp_deci_c = TEMP_W'($urandom);
			else
				s.temp_deci_c = TEMP_W'(int'($urandom_range(1650)) - 400);
			push_sample(s);
		end
	endtask

	task automatic program_cal(input logic [VOLT_W-1:0] v4, input logic [VOLT_W-1:0] v686,
			input logic [VOLT_W-1:0] v918);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [VOLT_W-1:0]    val [4];
		idx = '{REG_CAL_PH4, CFG_IDX_SPARE, REG_CAL_PH686, REG_CAL_PH918};
		val = '{v4, VOLT_W'($urandom), v686, v918};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_for_readings();
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		sample_t s;
		sb = new();
		set_v4   = '{16'd24000, 16'd0, 16'd65535, 16'd33000, 16'd0, 16'd30000,
			16'd18000, 16'd0, 16'd20001, 16'd0, 16'd0, 16'd23600};
		set_v686 = '{16'd20000, 16'd0, 16'd65535, 16'd16500, 16'd16500, 16'd33000,
			16'd9000, 16'd0, 16'd20000, 16'd0, 16'd0, 16'd20000};
		set_v918 = '{16'd16000, 16'd0, 16'd65535, 16'd0, 16'd33000, 16'd10000,
			16'd18000, 16'd0, 16'd20000, 16'd0, 16'd0, 16'd16700};
		foreach (set_v4[k]) begin
			if (k == 7 || k == 10) begin
				set_v4[k]   = VOLT_W'($urandom_range(33000, 20000));
				set_v918[k] = set_v4[k] - VOLT_W'($urandom_range(12000, 1));
				set_v686[k] = VOLT_W'($urandom_range(set_v4[k], set_v918[k]));
			end else if (k == 9) begin
				set_v4[k]   = VOLT_W'($urandom);
				set_v686[k] = VOLT_W'($urandom);
				set_v918[k] = VOLT_W'($urandom);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed groups under the reset calibration
		for (int i = 0; i < 3 * GROUP_LEN; i++) begin
			s.adc_sample  = SAMPLE_W'(DIR_ADC[i]);
			s.temp_deci_c = TEMP_W'(DIR_TEMP[i]);
			push_sample(s);
		end
		sample_valid <= 1'b0;
		wait_for_readings();
		repeat (SETTLE_CYCLES) @(posedge clk);

		for (int ph = 0; ph < N_SETTINGS; ph++) begin
			if (ph < 4) begin
				src_idle_pct  = 30;
				sink_idle_pct = 65;
			end else if (ph < 8) begin
				src_idle_pct  = 65;
				sink_idle_pct = 30;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			program_cal(set_v4[ph], set_v686[ph], set_v918[ph]);
			for (int g = 0; g < GROUPS_PER_SET; g++) begin
				if (ph == HOLD_PHASE && g == 6)
					long_hold_req <= 1'b1;
				if (ph == PAUSE_PHASE && g == 6) begin
					// hold the input until the output side has caught up
					sample_valid <= 1'b0;
					wait_for_readings();
					@(posedge clk);
				end
				send_group();
			end
			sample_valid <= 1'b0;
			wait_for_readings();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/phm_pkg.sv
hw/rtl/phm_accum.sv
hw/rtl/phm_mul.sv
hw/rtl/phm_div.sv
hw/rtl/ph_meter_trimmed_iir.sv
hw/rtl/phm_checker.sv
tb/ph_meter_trimmed_iir_tb.sv
